/* src/csv_byte_stream_parser_macros.svh */
// assertion macros for the csv byte stream parser
// no dependencies; taken in by the files that carry assertions
`ifndef CSV_BYTE_STREAM_PARSER_MACROS_SVH
`define CSV_BYTE_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CSVP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("csvp assertion failed");
// next-cycle implication, checked out of reset
`define CSVP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("csvp assertion failed");
`else
`define CSVP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSVP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* src/csvp_pkg.sv */
// shared types and constants of the csv byte stream parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csvp_pkg;

    localparam int ADDR_BITS = 4;

    localparam logic [1:0] REG_SKIP_LINES   = 2'd0;
    localparam logic [1:0] REG_FIRST_COLUMN = 2'd1;
    localparam logic [1:0] REG_DELIMITER    = 2'd2;

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_EOS  = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_CONTENT,
        KIND_FIELD_END,
        KIND_ROW_END,
        KIND_UNTERM_QUOTE,
        KIND_DONE,
        KIND_NO_DATA
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_PARSE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] column;
        logic [23:0] line_num;
        logic        last;
    } out_t;

    // all results caused by one input byte, count is 1 to 3
    typedef struct packed {
        out_t [2:0] res;
        logic [1:0] count;
    } group_t;

    typedef struct packed {
        logic [15:0] skip_lines;
        logic [15:0] first_column;
        logic [7:0]  delimiter;
    } cfg_t;

endpackage

`default_nettype wire

/* src/csvp_fifo.sv */
// short queue of result groups between the parser front and the output back
// depends on csvp_pkg
`timescale 1ns / 1ps
`default_nettype none

module csvp_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire csvp_pkg::group_t  push_data,
    input  wire logic              pop,
    output csvp_pkg::group_t       head,
    output logic                   full,
    output logic                   empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    csvp_pkg::group_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

`default_nettype wire

/* src/csvp_front.sv */
// parser front: takes one byte per transaction, runs skip, quote and field logic
// and hands every result group to the queue; depends on csvp_pkg
`timescale 1ns / 1ps
`default_nettype none

module csvp_front #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire csvp_pkg::cfg_t    cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire csvp_pkg::in_t     s_data,
    input  wire logic              q_full,
    output logic                   push_valid,
    output csvp_pkg::group_t       push_data
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    typedef struct packed {
        csvp_pkg::phase_t       phase;
        logic [15:0]            lines_skipped;
        logic                   quote_open;
        logic                   quote_pend;
        logic                   cr_pend;
        logic                   has_content;
        logic [COLUMN_BITS-1:0] col;
        logic [LINE_BITS-1:0]   line;
        logic                   any_row;
    } pstate_t;

    localparam pstate_t ST_RESET = '{
        phase: csvp_pkg::PH_SKIP, lines_skipped: 16'd0, quote_open: 1'b0,
        quote_pend: 1'b0, cr_pend: 1'b0, has_content: 1'b0, col: COL_ONE,
        line: '0, any_row: 1'b0};

    pstate_t st_reg, st_next, st;
    csvp_pkg::out_t [2:0] recs;
    logic [1:0] n;

    function automatic logic [LINE_BITS-1:0] line_tag(input logic [LINE_BITS-1:0] lc);
        return (lc < LINE_MAX) ? lc + 1'b1 : LINE_MAX;
    endfunction

    function automatic void emit(inout csvp_pkg::out_t [2:0] r, inout logic [1:0] cnt,
                                 input csvp_pkg::kind_t kind, input logic [7:0] b,
                                 input logic [15:0] col, input logic [23:0] line);
        if (cnt < 2'd3) begin
            r[cnt].kind     = kind;
            r[cnt].out_byte = b;
            r[cnt].column   = col;
            r[cnt].line_num = line;
            r[cnt].last     = 1'b0;
            cnt             = cnt + 2'd1;
        end
    endfunction

    function automatic void emit_here(inout pstate_t s, inout csvp_pkg::out_t [2:0] r,
                                      inout logic [1:0] cnt, input csvp_pkg::kind_t kind,
                                      input logic [7:0] b);
        emit(r, cnt, kind, b, 16'(s.col), 24'(line_tag(s.line)));
    endfunction

    function automatic logic col_on(input pstate_t s, input csvp_pkg::cfg_t c);
        return 16'(s.col) >= c.first_column;
    endfunction

    function automatic void take_char(inout pstate_t s, inout csvp_pkg::out_t [2:0] r,
                                      inout logic [1:0] cnt, input logic [7:0] ch,
                                      input csvp_pkg::cfg_t c);
        s.has_content = 1'b1;
        if (s.quote_open) begin
            if (ch == csvp_pkg::QUOTE_BYTE) begin
                s.quote_pend = 1'b1;
            end else if (col_on(s, c)) begin
                emit_here(s, r, cnt, csvp_pkg::KIND_CONTENT, ch);
            end
        end else if (ch == csvp_pkg::QUOTE_BYTE) begin
            s.quote_open = 1'b1;
        end else if (ch == c.delimiter) begin
            if (col_on(s, c)) begin
                emit_here(s, r, cnt, csvp_pkg::KIND_FIELD_END, 8'd0);
            end
            if (s.col < COL_MAX) begin
                s.col = s.col + 1'b1;
            end
        end else if (col_on(s, c)) begin
            emit_here(s, r, cnt, csvp_pkg::KIND_CONTENT, ch);
        end
    endfunction

    function automatic void end_line(inout pstate_t s, inout csvp_pkg::out_t [2:0] r,
                                     inout logic [1:0] cnt, input csvp_pkg::cfg_t c);
        if (s.quote_pend) begin
            s.quote_pend = 1'b0;
            s.quote_open = 1'b0;
        end
        s.cr_pend = 1'b0;
        if (s.has_content && s.quote_open) begin
            emit_here(s, r, cnt, csvp_pkg::KIND_UNTERM_QUOTE, 8'd0);
            s.phase = csvp_pkg::PH_ERROR;
            return;
        end
        if (s.has_content && col_on(s, c)) begin
            emit_here(s, r, cnt, csvp_pkg::KIND_FIELD_END, 8'd0);
            emit_here(s, r, cnt, csvp_pkg::KIND_ROW_END, 8'd0);
            s.any_row = 1'b1;
        end
        if (s.line < LINE_MAX) begin
            s.line = s.line + 1'b1;
        end
        s.col         = COL_ONE;
        s.has_content = 1'b0;
        s.quote_open  = 1'b0;
    endfunction

    function automatic void parse_byte(inout pstate_t s, inout csvp_pkg::out_t [2:0] r,
                                       inout logic [1:0] cnt, input logic [7:0] b,
                                       input csvp_pkg::cfg_t c);
        if (b == csvp_pkg::LF_BYTE) begin
            end_line(s, r, cnt, c);
            return;
        end
        if (b == csvp_pkg::CR_BYTE) begin
            if (s.quote_pend) begin
                s.quote_pend = 1'b0;
                s.quote_open = 1'b0;
            end
            // an earlier CR not followed by LF is plain text
            if (s.cr_pend) begin
                take_char(s, r, cnt, csvp_pkg::CR_BYTE, c);
            end
            s.cr_pend = 1'b1;
            return;
        end
        if (s.cr_pend) begin
            s.cr_pend = 1'b0;
            take_char(s, r, cnt, csvp_pkg::CR_BYTE, c);
        end
        if (s.quote_pend) begin
            s.quote_pend = 1'b0;
            // doubled quote inside quotes
            if (b == csvp_pkg::QUOTE_BYTE) begin
                if (col_on(s, c)) begin
                    emit_here(s, r, cnt, csvp_pkg::KIND_CONTENT, csvp_pkg::QUOTE_BYTE);
                end
                return;
            end
            s.quote_open = 1'b0;
        end
        take_char(s, r, cnt, b, c);
    endfunction

    assign s_ready = !q_full;

    always_comb begin
        st   = st_reg;
        recs = '0;
        n    = 2'd0;
        if (s_data.func == csvp_pkg::FUNC_DATA) begin
            case (st.phase)
                csvp_pkg::PH_SKIP: begin
                    if (st.lines_skipped < cfg.skip_lines) begin
                        if (s_data.data_byte == csvp_pkg::LF_BYTE) begin
                            st.lines_skipped = st.lines_skipped + 16'd1;
                        end
                    end else begin
                        st.phase = csvp_pkg::PH_PARSE;
                        parse_byte(st, recs, n, s_data.data_byte, cfg);
                    end
                end
                csvp_pkg::PH_PARSE: begin
                    parse_byte(st, recs, n, s_data.data_byte, cfg);
                end
                default: ;
            endcase
        end else begin
            if (st.phase == csvp_pkg::PH_ERROR) begin
                emit_here(st, recs, n, csvp_pkg::KIND_UNTERM_QUOTE, 8'd0);
            end else begin
                // an unfinished last line is closed as if LF had come
                if (st.phase == csvp_pkg::PH_PARSE && (st.has_content || st.cr_pend)) begin
                    end_line(st, recs, n, cfg);
                end
                if (st.phase != csvp_pkg::PH_ERROR) begin
                    emit(recs, n, st.any_row ? csvp_pkg::KIND_DONE : csvp_pkg::KIND_NO_DATA,
                         8'd0, 16'd0, 24'(st.line));
                end
            end
            st = ST_RESET;
        end
        st_next         = (s_valid && s_ready) ? st : st_reg;
        push_valid      = s_valid && s_ready && (n != 2'd0);
        push_data.res   = recs;
        push_data.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

/* src/csvp_back.sv */
// output back: walks each queued group one result per cycle, while m_ready allows, into the output register
// depends on csvp_pkg
`timescale 1ns / 1ps
`default_nettype none

module csvp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire csvp_pkg::group_t  head,
    input  wire logic              q_empty,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output csvp_pkg::out_t         m_data
);

    logic [1:0]     idx_reg, idx_next;
    logic           m_valid_reg, m_valid_next;
    csvp_pkg::out_t m_data_reg, m_data_next;
    logic           load, at_last;

    always_comb begin
        load         = !q_empty && (!m_valid_reg || m_ready);
        at_last      = (idx_reg == head.count - 2'd1);
        pop          = load && at_last;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next     = 1'b1;
            m_data_next      = head.res[idx_reg];
            m_data_next.last = at_last;
            idx_next         = at_last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* src/csv_byte_stream_parser.sv */
// Top level: APB register file, parser front, result queue and output back.
// An accepted byte's first result passes the result queue, then the output register, to m_valid.
// Throughput: one byte per cycle while m_ready stays high and each byte yields at most one result;
// a byte yielding several results has them sent one at a time by the back's serializer.
// Reset (aresetn low, synchronous) clears parser state, queue and output valid,
// and sets skip_lines 0, first_column 1, delimiter comma.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_byte_stream_parser_macros.svh"

module csv_byte_stream_parser #(
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire csvp_pkg::in_t                    s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output csvp_pkg::out_t                        m_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [csvp_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [15:0] skip_lines_reg, skip_lines_next;
    logic [15:0] first_column_reg, first_column_next;
    logic [7:0]  delimiter_reg, delimiter_next;
    logic [1:0]  reg_index;
    logic        wr_en;

    csvp_pkg::cfg_t   cfg;
    csvp_pkg::group_t push_data, head;
    logic             push_valid, q_full, q_empty, pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb begin
        skip_lines_next   = skip_lines_reg;
        first_column_next = first_column_reg;
        delimiter_next    = delimiter_reg;
        prdata            = 32'd0;
        case (reg_index)
            csvp_pkg::REG_SKIP_LINES: begin
                prdata = {16'd0, skip_lines_reg};
                if (wr_en) begin
                    skip_lines_next = pwdata[15:0];
                end
            end
            csvp_pkg::REG_FIRST_COLUMN: begin
                prdata = {16'd0, first_column_reg};
                if (wr_en) begin
                    first_column_next = pwdata[15:0];
                end
            end
            csvp_pkg::REG_DELIMITER: begin
                prdata = {24'd0, delimiter_reg};
                if (wr_en) begin
                    delimiter_next = pwdata[7:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_lines_reg   <= 16'd0;
            first_column_reg <= 16'd1;
            delimiter_reg    <= 8'd44;
        end else begin
            skip_lines_reg   <= skip_lines_next;
            first_column_reg <= first_column_next;
            delimiter_reg    <= delimiter_next;
        end
    end

    assign cfg.skip_lines   = skip_lines_reg;
    assign cfg.first_column = first_column_reg;
    assign cfg.delimiter    = delimiter_reg;

    csvp_front #(
        .LINE_BITS  (LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push_valid(push_valid),
        .push_data (push_data)
    );

    csvp_fifo #(
        .DEPTH(csvp_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    csvp_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .head   (head),
        .q_empty(q_empty),
        .pop    (pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // end of stream always closes the transaction's results
    `CSVP_ASSERT_IMP(a_done_is_last, aclk, aresetn, m_valid && (m_data.kind == csvp_pkg::KIND_DONE || m_data.kind == csvp_pkg::KIND_NO_DATA), m_data.last)
    `CSVP_ASSERT_IMP(a_done_no_column, aclk, aresetn, m_valid && (m_data.kind == csvp_pkg::KIND_DONE || m_data.kind == csvp_pkg::KIND_NO_DATA), m_data.column == 16'd0)
    `CSVP_ASSERT_IMP(a_text_has_column, aclk, aresetn, m_valid && m_data.kind != csvp_pkg::KIND_DONE && m_data.kind != csvp_pkg::KIND_NO_DATA, m_data.column != 16'd0)
    // end of stream always yields at least one result group
    `CSVP_ASSERT_NXT(a_eos_queued, aclk, aresetn, s_valid && s_ready && s_data.func == csvp_pkg::FUNC_EOS, !q_empty)

endmodule

`default_nettype wire
